[rtl/hstm_pkg.sv]
// Shared types, codes and the legality table of the health state transition monitor.
`default_nettype none

package hstm_pkg;

    // Number of health states: healthy, degraded, recovering, failed, shutdown.
    localparam int unsigned MODE_COUNT = 5;

    // Health state codes.
    localparam logic [2:0] MODE_HEALTHY    = 3'd0;
    localparam logic [2:0] MODE_DEGRADED   = 3'd1;
    localparam logic [2:0] MODE_RECOVERING = 3'd2;
    localparam logic [2:0] MODE_FAILED     = 3'd3;
    localparam logic [2:0] MODE_SHUTDOWN   = 3'd4;

    // Operation selector carried on the request side channel.
    typedef enum logic [1:0] {
        FUNC_TRANSITION    = 2'd0,
        FUNC_READ_SLOT     = 2'd1,
        FUNC_READ_DURATION = 2'd2,
        FUNC_RESET_STATS   = 2'd3
    } func_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_SUCCESS       = 2'd0,
        STATUS_INVALID       = 2'd1,
        STATUS_BLOCKED       = 2'd2,
        STATUS_ACTION_FAILED = 2'd3
    } status_t;

    // One history ring entry.
    typedef struct packed {
        logic [2:0]  src_mode;
        logic [2:0]  dst_mode;
        logic [31:0] stamp;
        logic [31:0] reason;
    } log_entry_t;

    // Write request into the history ring; the address travels separately
    // because its width follows the ring depth.
    typedef struct packed {
        logic       en;
        log_entry_t entry;
    } ring_write_t;

    // Legal target set of each state, one bit per target state code.
    function automatic logic legal_move(input logic [2:0] from_mode, input logic [2:0] to_mode);
        logic [7:0] row;
        case (from_mode)
            MODE_HEALTHY:    row = 8'b0001_1010;
            MODE_DEGRADED:   row = 8'b0001_1101;
            MODE_RECOVERING: row = 8'b0001_1011;
            MODE_FAILED:     row = 8'b0001_0100;
            MODE_SHUTDOWN:   row = 8'b0000_0000;
            default:         row = 8'b0000_0000;
        endcase
        return row[to_mode];
    endfunction

endpackage

`default_nettype wire

[rtl/hstm_ring.sv]
// History ring memory with per-entry valid bits and write-through on a same-slot read.
`default_nettype none

module hstm_ring #(
    parameter int unsigned DEPTH = 16
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  hstm_pkg::ring_write_t            wr_req,
    input  wire  [$clog2(DEPTH)-1:0]         wr_addr,
    input  wire                              rd_en,
    input  wire  [$clog2(DEPTH)-1:0]         rd_addr,
    output hstm_pkg::log_entry_t             rd_entry
);
    import hstm_pkg::*;

    log_entry_t       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    log_entry_t       rd_data_reg;
    log_entry_t       byp_data_reg;
    logic             byp_hit_reg;
    logic             rd_vld_reg;
    logic             same_slot;

    assign same_slot = wr_req.en && (wr_addr == rd_addr);

    // Storage array: one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_addr] <= wr_req.entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits make never-written slots read back as zero after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_req.en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // A read in the same cycle as a write to that slot takes the new entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_hit_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else if (rd_en) begin
            byp_hit_reg <= same_slot;
            rd_vld_reg  <= vld_reg[rd_addr] | same_slot;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byp_data_reg <= wr_req.entry;
        end
    end

    // Read data: zero for an unwritten slot, forwarded entry on a same-slot hit.
    always_comb begin
        if (!rd_vld_reg) begin
            rd_entry = '0;
        end else if (byp_hit_reg) begin
            rd_entry = byp_data_reg;
        end else begin
            rd_entry = rd_data_reg;
        end
    end

endmodule

`default_nettype wire

[rtl/health_state_transition_monitor_unit.sv]
// Top level of the health state transition monitor: request, update and result stages.
`default_nettype none

// Five-state health monitor (healthy, degraded, recovering, failed, shutdown).
// Each request on the s_ side is a transition, a history slot read, a duration
// read or a statistics reset, selected by s_tuser. The block takes one request
// per clock cycle while the result side is not stalled and returns exactly one
// result per request: the request is registered, the whole state update is
// combinational, and the result is registered. The history ring read is issued
// as the request is taken, so the registered read data is ready when the request
// reaches the update logic. The ring starts out reading as all zeros after reset;
// a statistics reset clears the counters and duration totals but keeps the ring.
module health_state_transition_monitor_unit #(
    parameter int unsigned HISTORY_DEPTH = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    // Request channel.
    input  wire          s_tvalid,
    output logic         s_tready,
    // From bit 0: target_state[3], reason[32], now_time[32], guard_ok[1],
    // exit_ok[1], entry_ok[1], slot_index[4], zero fill[6].
    input  wire  [79:0]  s_tdata,
    // From bit 0: func[2].
    input  wire  [1:0]   s_tuser,
    // Result channel.
    output logic         m_tvalid,
    input  wire          m_tready,
    // From bit 0: status[2], present_state[3], attempt_total[32], failure_total[32],
    // logged_count[5], slot_from[3], slot_to[3], slot_time[32], slot_reason[32],
    // duration[64].
    output logic [207:0] m_tdata
);
    import hstm_pkg::*;

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);
    localparam int unsigned FW = $clog2(HISTORY_DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(HISTORY_DEPTH);

    // Request register.
    logic        in_valid_reg;
    func_t       in_func_reg;
    logic [2:0]  in_target_reg;
    logic [31:0] in_reason_reg;
    logic [31:0] in_now_reg;
    logic        in_guard_reg;
    logic        in_exit_reg;
    logic        in_entry_reg;
    logic [3:0]  in_slot_reg;

    // Monitor state.
    logic [2:0]    mode_reg,     mode_next;
    logic [31:0]   stamp_reg,    stamp_next;
    logic [63:0]   tis_reg [MODE_COUNT];
    logic [63:0]   tis_next [MODE_COUNT];
    logic [31:0]   attempts_reg, attempts_next;
    logic [31:0]   failures_reg, failures_next;
    logic [AW-1:0] head_reg,     head_next;
    logic [FW-1:0] fill_reg,     fill_next;

    // Result register.
    logic          out_valid_reg;
    logic [207:0]  out_data_reg, out_data_next;

    logic          accept;
    logic          fire;
    logic          out_free;

    ring_write_t   ring_wr;
    log_entry_t    ring_rd;
    logic [AW-1:0] rd_addr;

    status_t       status;
    log_entry_t    slot_entry;
    logic [63:0]   duration;
    logic [63:0]   stay;
    logic [63:0]   tis_sel;
    logic          target_ok;
    logic          slot_ok;

    // Handshake: a request moves on when the result register is free or drains.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Ring read address taken straight from the incoming request.
    assign rd_addr = AW'(s_tdata[73:70]);

    hstm_ring #(
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_req   (ring_wr),
        .wr_addr  (head_reg),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .rd_entry (ring_rd)
    );

    // Request register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_func_reg   <= func_t'(s_tuser);
            in_target_reg <= s_tdata[2:0];
            in_reason_reg <= s_tdata[34:3];
            in_now_reg    <= s_tdata[66:35];
            in_guard_reg  <= s_tdata[67];
            in_exit_reg   <= s_tdata[68];
            in_entry_reg  <= s_tdata[69];
            in_slot_reg   <= s_tdata[73:70];
        end
    end

    // Time spent in the current state, zero without a stamp or if the clock went back.
    always_comb begin
        if (stamp_reg != 32'd0 && in_now_reg >= stamp_reg) begin
            stay = {32'd0, in_now_reg - stamp_reg};
        end else begin
            stay = 64'd0;
        end
    end

    // Duration total of the queried state.
    always_comb begin
        tis_sel = 64'd0;
        for (int i = 0; i < MODE_COUNT; i++) begin
            if (in_target_reg == 3'(i)) begin
                tis_sel = tis_reg[i];
            end
        end
    end

    assign target_ok = (32'(in_target_reg) < 32'(MODE_COUNT));
    assign slot_ok   = (32'(in_slot_reg) < 32'(HISTORY_DEPTH));

    // State update and result for the request in the request register.
    always_comb begin
        mode_next     = mode_reg;
        stamp_next    = stamp_reg;
        attempts_next = attempts_reg;
        failures_next = failures_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        for (int i = 0; i < MODE_COUNT; i++) begin
            tis_next[i] = tis_reg[i];
        end
        status            = STATUS_SUCCESS;
        slot_entry        = '0;
        duration          = 64'd0;
        ring_wr.en        = 1'b0;
        ring_wr.entry     = '0;
        ring_wr.entry.src_mode = mode_reg;
        ring_wr.entry.dst_mode = in_target_reg;
        ring_wr.entry.stamp    = in_now_reg;
        ring_wr.entry.reason   = in_reason_reg;

        if (fire) begin
            case (in_func_reg)
                FUNC_TRANSITION: begin
                    if (!target_ok) begin
                        status = STATUS_INVALID;
                    end else begin
                        attempts_next = attempts_reg + 32'd1;
                        if (mode_reg == in_target_reg) begin
                            status = STATUS_SUCCESS;
                        end else if (!legal_move(mode_reg, in_target_reg)) begin
                            failures_next = failures_reg + 32'd1;
                            status        = STATUS_INVALID;
                        end else if (!in_guard_reg) begin
                            failures_next = failures_reg + 32'd1;
                            status        = STATUS_BLOCKED;
                        end else if (!in_exit_reg) begin
                            failures_next = failures_reg + 32'd1;
                            status        = STATUS_ACTION_FAILED;
                        end else begin
                            // Close out the old state's stay and move on.
                            for (int i = 0; i < MODE_COUNT; i++) begin
                                if (mode_reg == 3'(i)) begin
                                    tis_next[i] = tis_reg[i] + stay;
                                end
                            end
                            mode_next  = in_target_reg;
                            stamp_next = in_now_reg;
                            if (!in_entry_reg) begin
                                failures_next = failures_reg + 32'd1;
                                status        = STATUS_ACTION_FAILED;
                            end else begin
                                ring_wr.en = 1'b1;
                                head_next  = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                                if (fill_reg != FULL_FILL) begin
                                    fill_next = fill_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                FUNC_READ_SLOT: begin
                    if (slot_ok) begin
                        slot_entry = ring_rd;
                    end else begin
                        status = STATUS_INVALID;
                    end
                end
                FUNC_READ_DURATION: begin
                    if (target_ok) begin
                        duration = (mode_reg == in_target_reg) ? tis_sel + stay : tis_sel;
                    end else begin
                        status = STATUS_INVALID;
                    end
                end
                FUNC_RESET_STATS: begin
                    for (int i = 0; i < MODE_COUNT; i++) begin
                        tis_next[i] = 64'd0;
                    end
                    attempts_next = 32'd0;
                    failures_next = 32'd0;
                    stamp_next    = in_now_reg;
                end
                default: begin
                    status = STATUS_SUCCESS;
                end
            endcase
        end

        out_data_next = {duration,
                         slot_entry.reason,
                         slot_entry.stamp,
                         slot_entry.dst_mode,
                         slot_entry.src_mode,
                         5'(fill_next),
                         failures_next,
                         attempts_next,
                         mode_next,
                         status};
    end

    // Monitor state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_HEALTHY;
            stamp_reg    <= 32'd0;
            attempts_reg <= 32'd0;
            failures_reg <= 32'd0;
            head_reg     <= '0;
            fill_reg     <= '0;
            for (int i = 0; i < MODE_COUNT; i++) begin
                tis_reg[i] <= 64'd0;
            end
        end else begin
            mode_reg     <= mode_next;
            stamp_reg    <= stamp_next;
            attempts_reg <= attempts_next;
            failures_reg <= failures_next;
            head_reg     <= head_next;
            fill_reg     <= fill_next;
            for (int i = 0; i < MODE_COUNT; i++) begin
                tis_reg[i] <= tis_next[i];
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

[verif/health_state_transition_monitor_unit_test.sv]
// Self-checking testbench of the health state transition monitor unit.
`timescale 1ns / 100ps

module health_state_transition_monitor_unit_test;
    import hstm_pkg::*;

    localparam int unsigned RING_DEPTH = 16;
    localparam int unsigned RANDOM_REQUESTS = 650;

    // One request as the sender sees it, plus a flag that makes the driver drain first.
    typedef struct packed {
        func_t       func;
        logic [2:0]  target;
        logic [31:0] reason;
        logic [31:0] now;
        logic        guard_ok;
        logic        exit_ok;
        logic        entry_ok;
        logic [3:0]  slot;
        logic        drain_first;
    } health_request_t;

    // One result, laid out exactly as m_tdata (status in the lowest bits).
    typedef struct packed {
        logic [63:0] duration;
        logic [31:0] slot_reason;
        logic [31:0] slot_time;
        logic [2:0]  slot_to;
        logic [2:0]  slot_from;
        logic [4:0]  logged_count;
        logic [31:0] failure_total;
        logic [31:0] attempt_total;
        logic [2:0]  present_state;
        logic [1:0]  status;
    } health_report_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [79:0]    s_tdata = '0;
    logic [1:0]     s_tuser = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [207:0]   m_tdata;

    health_state_transition_monitor_unit #(
        .HISTORY_DEPTH(RING_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // Requests waiting to be sent and results the predictor expects.
    health_request_t pending_requests[$];
    health_report_t  predicted_reports[$];
    health_request_t drive_req = '0;
    health_request_t next_req;
    int unsigned     total_requests = 0;
    int unsigned     issued_count = 0;
    int unsigned     retired_count = 0;
    int unsigned     error_count = 0;
    logic            tail_phase = 1'b0;

    // Predicted block state.
    logic [2:0]  mdl_mode;
    logic [31:0] mdl_entry_stamp;
    logic [63:0] mdl_dwell [0:4];
    logic [31:0] mdl_attempts;
    logic [31:0] mdl_failures;
    logic [5:0]  mdl_log_moves [0:RING_DEPTH-1];
    logic [31:0] mdl_log_stamps [0:RING_DEPTH-1];
    logic [31:0] mdl_log_reasons [0:RING_DEPTH-1];
    logic [3:0]  mdl_log_head;
    logic [4:0]  mdl_log_fill;

    // Stimulus-side view of the state, used to steer requests into legal moves.
    logic [2:0]  gen_mode = MODE_HEALTHY;
    logic [31:0] gen_clock = '0;
    logic        drain_next = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Legality table of the health machine, one bit per target state.
    function automatic logic move_allowed(input logic [2:0] from_mode, input logic [2:0] to_mode);
        logic [4:0] row;
        case (from_mode)
            MODE_HEALTHY:    row = 5'b11010;
            MODE_DEGRADED:   row = 5'b11101;
            MODE_RECOVERING: row = 5'b11011;
            MODE_FAILED:     row = 5'b10100;
            default:         row = 5'b00000;
        endcase
        return (to_mode < MODE_COUNT) ? row[to_mode] : 1'b0;
    endfunction

    // Time spent in the present state; zero if the stamp is unset or the clock went back.
    function automatic logic [63:0] current_stay(input logic [31:0] now);
        if (mdl_entry_stamp != 0 && now >= mdl_entry_stamp) begin
            return {32'd0, now - mdl_entry_stamp};
        end
        return 64'd0;
    endfunction

    // Apply one accepted request to the predicted state and queue its result.
    task automatic predict_health_step(input health_request_t r);
        health_report_t rep;
        logic [2:0]     old_mode;
        begin
            rep = '0;
            old_mode = mdl_mode;
            case (r.func)
                FUNC_TRANSITION: begin
                    if (r.target >= MODE_COUNT) begin
                        rep.status = STATUS_INVALID;
                    end else begin
                        mdl_attempts = mdl_attempts + 1;
                        if (old_mode == r.target) begin
                            rep.status = STATUS_SUCCESS;
                        end else if (!move_allowed(old_mode, r.target)) begin
                            mdl_failures = mdl_failures + 1;
                            rep.status = STATUS_INVALID;
                        end else if (!r.guard_ok) begin
                            mdl_failures = mdl_failures + 1;
                            rep.status = STATUS_BLOCKED;
                        end else if (!r.exit_ok) begin
                            mdl_failures = mdl_failures + 1;
                            rep.status = STATUS_ACTION_FAILED;
                        end else begin
                            // The move happens; a failed entry action skips the log and counts as a failure.
                            mdl_dwell[old_mode] = mdl_dwell[old_mode] + current_stay(r.now);
                            mdl_mode = r.target;
                            mdl_entry_stamp = r.now;
                            if (!r.entry_ok) begin
                                mdl_failures = mdl_failures + 1;
                                rep.status = STATUS_ACTION_FAILED;
                            end else begin
                                mdl_log_moves[mdl_log_head] = {old_mode, r.target};
                                mdl_log_stamps[mdl_log_head] = r.now;
                                mdl_log_reasons[mdl_log_head] = r.reason;
                                mdl_log_head = mdl_log_head + 4'd1;
                                if (mdl_log_fill < RING_DEPTH) begin
                                    mdl_log_fill = mdl_log_fill + 5'd1;
                                end
                                rep.status = STATUS_SUCCESS;
                            end
                        end
                    end
                end
                FUNC_READ_SLOT: begin
                    rep.slot_from = mdl_log_moves[r.slot][5:3];
                    rep.slot_to = mdl_log_moves[r.slot][2:0];
                    rep.slot_time = mdl_log_stamps[r.slot];
                    rep.slot_reason = mdl_log_reasons[r.slot];
                    rep.status = STATUS_SUCCESS;
                end
                FUNC_READ_DURATION: begin
                    if (r.target < MODE_COUNT) begin
                        rep.duration = mdl_dwell[r.target];
                        if (mdl_mode == r.target) begin
                            rep.duration = rep.duration + current_stay(r.now);
                        end
                        rep.status = STATUS_SUCCESS;
                    end else begin
                        rep.status = STATUS_INVALID;
                    end
                end
                default: begin
                    // Statistics reset keeps the ring and the present state.
                    for (int i = 0; i < MODE_COUNT; i++) begin
                        mdl_dwell[i] = 64'd0;
                    end
                    mdl_attempts = 32'd0;
                    mdl_failures = 32'd0;
                    mdl_entry_stamp = r.now;
                    rep.status = STATUS_SUCCESS;
                end
            endcase
            rep.present_state = mdl_mode;
            rep.attempt_total = mdl_attempts;
            rep.failure_total = mdl_failures;
            rep.logged_count = mdl_log_fill;
            predicted_reports.push_back(rep);
        end
    endtask

    // Queue one request and follow the state it will leave the block in.
    task automatic enqueue_request(input func_t f, input logic [2:0] tgt, input logic [31:0] rsn,
                                   input logic [31:0] now, input logic g, input logic x,
                                   input logic e, input logic [3:0] slot);
        health_request_t r;
        begin
            r = '{func: f, target: tgt, reason: rsn, now: now, guard_ok: g, exit_ok: x,
                  entry_ok: e, slot: slot, drain_first: drain_next};
            drain_next = 1'b0;
            if (f == FUNC_TRANSITION && tgt < MODE_COUNT && tgt != gen_mode
                    && move_allowed(gen_mode, tgt) && g && x) begin
                gen_mode = tgt;
            end
            pending_requests.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    // Sender: bursts of requests separated by random gaps.
    int unsigned burst_left = 0;
    int unsigned idle_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (idle_left != 0) begin
                idle_left <= idle_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() == 0) begin
                s_tvalid <= 1'b0;
            end else if (pending_requests[0].drain_first
                    && (issued_count != retired_count || (s_tvalid && s_tready))) begin
                // Hold off until every outstanding result has come back.
                s_tvalid <= 1'b0;
            end else begin
                next_req = pending_requests.pop_front();
                drive_req <= next_req;
                s_tdata <= {6'd0, next_req.slot, next_req.entry_ok, next_req.exit_ok,
                            next_req.guard_ok, next_req.now, next_req.reason, next_req.target};
                s_tuser <= next_req.func;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    idle_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: rotating stall pattern, redrawn each time the 6-bit tick counter wraps.
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [5:0]  pattern_tick = '0;

    always @(posedge aclk) begin
        pattern_tick <= pattern_tick + 6'd1;
        if (pattern_tick == 6'd63) begin
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0101);
        end else begin
            ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
        end
        m_tready <= tail_phase | ready_pattern[15];
    end

    // Monitor: check each result, then predict the request taken at this edge.
    health_report_t want_rep;
    health_report_t got_rep;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (predicted_reports.size() == 0) begin
                    $error("result with no request outstanding: %0h", m_tdata);
                    error_count++;
                end else begin
                    want_rep = predicted_reports.pop_front();
                    got_rep = health_report_t'(m_tdata);
                    check_field("status", 64'(want_rep.status), 64'(got_rep.status));
                    check_field("present_state", 64'(want_rep.present_state),
                                64'(got_rep.present_state));
                    check_field("attempt_total", 64'(want_rep.attempt_total),
                                64'(got_rep.attempt_total));
                    check_field("failure_total", 64'(want_rep.failure_total),
                                64'(got_rep.failure_total));
                    check_field("logged_count", 64'(want_rep.logged_count),
                                64'(got_rep.logged_count));
                    check_field("slot_from", 64'(want_rep.slot_from), 64'(got_rep.slot_from));
                    check_field("slot_to", 64'(want_rep.slot_to), 64'(got_rep.slot_to));
                    check_field("slot_time", 64'(want_rep.slot_time), 64'(got_rep.slot_time));
                    check_field("slot_reason", 64'(want_rep.slot_reason),
                                64'(got_rep.slot_reason));
                    check_field("duration", want_rep.duration, got_rep.duration);
                    retired_count <= retired_count + 1;
                end
            end
            if (s_tvalid && s_tready) begin
                predict_health_step(drive_req);
                issued_count <= issued_count + 1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        int unsigned   sel;
        int unsigned   tsel;
        logic [2:0]    tgt;
        logic          g;
        logic          x;
        logic          e;

        mdl_mode = MODE_HEALTHY;
        mdl_entry_stamp = '0;
        mdl_attempts = '0;
        mdl_failures = '0;
        mdl_log_head = '0;
        mdl_log_fill = '0;
        for (int i = 0; i < MODE_COUNT; i++) begin
            mdl_dwell[i] = '0;
        end
        for (int i = 0; i < RING_DEPTH; i++) begin
            mdl_log_moves[i] = '0;
            mdl_log_stamps[i] = '0;
            mdl_log_reasons[i] = '0;
        end

        // Directed opening: empty ring, invalid targets, each refusal, time accounting edges.
        enqueue_request(FUNC_READ_SLOT, MODE_HEALTHY, 32'd0, 32'd0, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_READ_SLOT, MODE_HEALTHY, 32'd0, 32'd0, 1, 1, 1, 4'd15);
        enqueue_request(FUNC_READ_DURATION, MODE_HEALTHY, 32'd0, 32'd50, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_READ_DURATION, 3'd7, 32'd0, 32'd60, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, 3'd6, 32'd1, 32'd10, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, 3'd5, 32'd1, 32'd10, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, MODE_HEALTHY, 32'd2, 32'd20, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, MODE_RECOVERING, 32'd3, 32'd30, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, MODE_DEGRADED, 32'd4, 32'd40, 0, 1, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, MODE_DEGRADED, 32'd5, 32'd50, 1, 0, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, MODE_DEGRADED, 32'd0, 32'd100, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, MODE_RECOVERING, 32'd7, 32'd250, 1, 1, 0, 4'd0);
        enqueue_request(FUNC_TRANSITION, MODE_HEALTHY, 32'hFFFF_FFFF, 32'd200, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_READ_DURATION, MODE_DEGRADED, 32'd0, 32'd300, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_READ_DURATION, MODE_HEALTHY, 32'd0, 32'd400, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_RESET_STATS, MODE_HEALTHY, 32'd0, 32'd0, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, MODE_FAILED, 32'hA5A5_5A5A, 32'hFFFF_FFF0,
                        1, 1, 1, 4'd0);
        enqueue_request(FUNC_READ_DURATION, MODE_FAILED, 32'd0, 32'hFFFF_FFFF, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_TRANSITION, MODE_RECOVERING, 32'd0, 32'hFFFF_FFFF, 1, 1, 1, 4'd0);
        for (int i = 0; i < 4; i++) begin
            enqueue_request(FUNC_READ_SLOT, MODE_HEALTHY, 32'd0, 32'd0, 1, 1, 1, 4'(i));
        end
        enqueue_request(FUNC_RESET_STATS, MODE_HEALTHY, 32'd0, 32'hFFFF_FFFF, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_READ_DURATION, MODE_RECOVERING, 32'd0, 32'd0, 1, 1, 1, 4'd0);

        // Random part: mostly legal moves with random verdicts, shutdown kept for the end.
        gen_clock = 32'd1000;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            tsel = $urandom_range(0, 99);
            if (tsel < 80) begin
                gen_clock = gen_clock + $urandom_range(0, 2000);
            end else if (tsel < 88) begin
                gen_clock = gen_clock - $urandom_range(1, 5000);
            end else if (tsel < 93) begin
                gen_clock = $urandom;
            end else if (tsel < 96) begin
                gen_clock = 32'd0;
            end else begin
                gen_clock = 32'hFFFF_FFFF - $urandom_range(0, 100);
            end
            if (n % 97 == 50) begin
                drain_next = 1'b1;
            end
            sel = $urandom_range(0, 99);
            if (sel < 62) begin
                tsel = $urandom_range(0, 99);
                if (tsel < 75) begin
                    do begin
                        tgt = 3'($urandom_range(0, 3));
                    end while (!move_allowed(gen_mode, tgt));
                end else if (tsel < 82) begin
                    tgt = gen_mode;
                end else if (tsel < 90) begin
                    tgt = 3'($urandom_range(0, 4));
                end else begin
                    tgt = 3'($urandom_range(5, 7));
                end
                g = ($urandom_range(0, 9) != 0);
                x = ($urandom_range(0, 9) != 0);
                e = ($urandom_range(0, 7) != 0);
                // A move into shutdown would end all further movement.
                if (tgt == MODE_SHUTDOWN && move_allowed(gen_mode, tgt) && g && x) begin
                    if ($urandom_range(0, 1) == 0) begin
                        g = 1'b0;
                    end else begin
                        x = 1'b0;
                    end
                end
                enqueue_request(FUNC_TRANSITION, tgt, $urandom, gen_clock, g, x, e,
                                4'($urandom_range(0, 15)));
            end else if (sel < 77) begin
                enqueue_request(FUNC_READ_SLOT, 3'($urandom_range(0, 7)), $urandom, gen_clock,
                                1'($urandom), 1'($urandom), 1'($urandom),
                                4'($urandom_range(0, 15)));
            end else if (sel < 92) begin
                tgt = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
                enqueue_request(FUNC_READ_DURATION, tgt, $urandom, gen_clock, 1'($urandom),
                                1'($urandom), 1'($urandom), 4'($urandom_range(0, 15)));
            end else begin
                enqueue_request(FUNC_RESET_STATS, 3'($urandom_range(0, 7)), $urandom, gen_clock,
                                1'($urandom), 1'($urandom), 1'($urandom),
                                4'($urandom_range(0, 15)));
            end
        end

        // Closing: enter shutdown, then confirm it has no way out.
        drain_next = 1'b1;
        gen_clock = gen_clock + 32'd17;
        enqueue_request(FUNC_TRANSITION, MODE_SHUTDOWN, 32'hDEAD_0004, gen_clock, 1, 1, 1, 4'd0);
        for (int i = 0; i < MODE_COUNT; i++) begin
            gen_clock = gen_clock + 32'd5;
            enqueue_request(FUNC_TRANSITION, 3'(i), $urandom, gen_clock, 1, 1, 1, 4'd0);
        end
        enqueue_request(FUNC_READ_DURATION, MODE_SHUTDOWN, 32'd0, gen_clock + 32'd9,
                        1, 1, 1, 4'd0);
        enqueue_request(FUNC_RESET_STATS, MODE_HEALTHY, 32'd0, gen_clock + 32'd10, 1, 1, 1, 4'd0);
        enqueue_request(FUNC_READ_DURATION, MODE_SHUTDOWN, 32'd0, gen_clock + 32'd30,
                        1, 1, 1, 4'd0);
        enqueue_request(FUNC_READ_SLOT, MODE_HEALTHY, 32'd0, gen_clock, 1, 1, 1,
                        4'($urandom_range(0, 15)));
        total_requests = pending_requests.size();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (issued_count != total_requests || retired_count != total_requests) begin
            @(posedge aclk);
        end
        tail_phase <= 1'b1;
        repeat (10) @(posedge aclk);
        if (predicted_reports.size() != 0) begin
            $error("%0d expected results never arrived", predicted_reports.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("health_state_transition_monitor_unit_test: done, clean");
        end else begin
            $display("health_state_transition_monitor_unit_test: done, errors");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("health_state_transition_monitor_unit_test: done, errors");
        $finish;
    end

endmodule

[health_state_transition_monitor_unit.f]
rtl/hstm_pkg.sv
rtl/hstm_ring.sv
rtl/health_state_transition_monitor_unit.sv
verif/health_state_transition_monitor_unit_test.sv
